// ===== rtl/sss_pkg.sv =====
// ============================================================================
// Schedule setpoint selector package
// Shared types, codes and constants for the setpoint selector block.
// ============================================================================
package sss_pkg;

    // Default number of slots per schedule table (slot 0 is the default slot).
    localparam int NUM_SLOTS_DEF = 8;

    // A slot is a candidate in the first pass when minute - start is non-negative and below this.
    localparam int SEARCH_LIMIT  = 2000;

    localparam int MINUTE_W = 11;
    localparam int START_W  = 12;
    localparam int TEMP_W   = 16;
    localparam int CMD_W    = 2;
    localparam int SIDX_W   = 3;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;

    // Start minute of an unused slot.
    localparam logic signed [START_W-1:0] UNUSED_START = '1;

    typedef enum logic [CMD_W-1:0] {
        CMD_WRITE_SLOT   = 2'd0,
        CMD_SET_OVERRIDE = 2'd1,
        CMD_QUERY        = 2'd2,
        CMD_CHECK        = 2'd3
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_COOL_MODE         = 2'd0,
        REG_VACATION_ENABLE   = 2'd1,
        REG_VACATION_SETPOINT = 2'd2
    } t_reg_idx;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FINISH
    } t_state;

    typedef struct packed {
        logic signed [START_W-1:0] start;
        logic signed [TEMP_W-1:0]  temp;
    } t_slot_entry;

    // Contents of a slot that was never written.
    localparam t_slot_entry RESET_ENTRY = '{start: UNUSED_START, temp: '0};

endpackage

// ===== rtl/sss_slot_ram.sv =====
// ============================================================================
// Slot table memory
// Holds both schedule tables, one write and one registered read per cycle.
// ============================================================================
module sss_slot_ram #(
    parameter int NUM_SLOTS = sss_pkg::NUM_SLOTS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_wr_en,
    input  logic [$clog2(2*NUM_SLOTS)-1:0] i_wr_addr,
    input  sss_pkg::t_slot_entry        i_wr_entry,
    input  logic                        i_rd_en,
    input  logic [$clog2(2*NUM_SLOTS)-1:0] i_rd_addr,
    output sss_pkg::t_slot_entry        o_rd_entry
);

    localparam int DEPTH = 2 * NUM_SLOTS;

    sss_pkg::t_slot_entry r_mem [DEPTH];
    logic [DEPTH-1:0]     r_vld;
    sss_pkg::t_slot_entry r_rd_entry;
    logic                 r_rd_vld;

    // Each entry carries a valid bit so that reset makes every slot unused at once.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_vld[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_vld <= r_vld[i_rd_addr];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_entry;
        end
        if (i_rd_en) begin
            r_rd_entry <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_entry = r_rd_vld ? r_rd_entry : sss_pkg::RESET_ENTRY;

endmodule

// ===== rtl/schedule_setpoint_selector_unit.sv =====
// ============================================================================
// Schedule setpoint selector
// Heat and cool schedule tables with override and vacation handling.
// ============================================================================
//
// Channel   Direction  Handshake                  Word
// -------   ---------  -------------------------  --------------------------------------
// in        input      i_in_valid / o_in_ready    cmd, minute, table, slot, start, temp
// out       output     o_out_valid / i_out_ready  setpoint, override reached/held
// cfg       input      i_cfg_we (no wait)         register index and write data
//
// A word that reads the schedule (set override, or a query outside vacation mode)
// scans the table before it reaches the result register: the slot memory has
// one read port, so the table is scanned one slot per cycle through a single
// subtract and compare unit. All other words go straight to the final state.
// The block is ready again in the cycle after the result is loaded. Reset is
// synchronous and active low; it marks every slot unused through the memory's
// valid bits, so no clearing pass is needed and a word is taken at once.
// The result sits in an output register; a new input word is taken while it waits.
// A stalled output only holds the block in its final cycle before state is updated.
//
module schedule_setpoint_selector_unit #(
    parameter int NUM_SLOTS = sss_pkg::NUM_SLOTS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Configuration write port
    input  logic                              i_cfg_we,
    input  logic [sss_pkg::CFG_IDX_W-1:0]     i_cfg_addr,
    input  logic [sss_pkg::CFG_DATA_W-1:0]    i_cfg_wdata,
    // Input words
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [sss_pkg::CMD_W-1:0]         i_cmd,
    input  logic [sss_pkg::MINUTE_W-1:0]      i_minute_of_day,
    input  logic                              i_table_select,
    input  logic [sss_pkg::SIDX_W-1:0]        i_slot_index,
    input  logic signed [sss_pkg::START_W-1:0] i_slot_start,
    input  logic signed [sss_pkg::TEMP_W-1:0] i_temp_value,
    // Result words
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic signed [sss_pkg::TEMP_W-1:0] o_setpoint,
    output logic                              o_override_reached,
    output logic                              o_override_held
);

    localparam int SLOT_W = $clog2(NUM_SLOTS);
    localparam int IDX_W  = SLOT_W + 1;
    localparam int ADDR_W = $clog2(2 * NUM_SLOTS);
    localparam int MW     = sss_pkg::MINUTE_W;
    localparam int TW     = sss_pkg::TEMP_W;
    localparam int SW     = sss_pkg::START_W;

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    sss_pkg::t_state          r_state, n_state;

    // Configuration
    logic                     r_cool_mode, n_cool_mode;
    logic                     r_vac_en, n_vac_en;
    logic signed [TW-1:0]     r_vac_sp, n_vac_sp;

    // Override and target state
    logic                     r_ovr_active, n_ovr_active;
    logic [SLOT_W-1:0]        r_ovr_slot, n_ovr_slot;
    logic signed [TW-1:0]     r_ovr_temp, n_ovr_temp;
    logic signed [TW-1:0]     r_target, n_target;

    // Latched input word
    sss_pkg::t_cmd            r_cmd, n_cmd;
    logic [MW-1:0]            r_minute, n_minute;
    logic                     r_tsel, n_tsel;
    logic [sss_pkg::SIDX_W-1:0] r_sidx, n_sidx;
    logic signed [SW-1:0]     r_sstart, n_sstart;
    logic signed [TW-1:0]     r_tval, n_tval;

    // Scan sequencer and best-slot trackers
    logic [IDX_W-1:0]         r_idx, n_idx;
    logic                     r_pend, n_pend;
    logic [SLOT_W-1:0]        r_pidx, n_pidx;
    logic [MW-1:0]            r_best1, n_best1;
    logic [SLOT_W-1:0]        r_sel1, n_sel1;
    logic signed [TW-1:0]     r_t1, n_t1;
    logic [MW-1:0]            r_best2, n_best2;
    logic [SLOT_W-1:0]        r_sel2, n_sel2;
    logic signed [TW-1:0]     r_t2, n_t2;
    logic signed [TW-1:0]     r_temp0, n_temp0;

    // Output register
    logic                     r_out_valid, n_out_valid;
    logic signed [TW-1:0]     r_out_sp, n_out_sp;
    logic                     r_out_reached, n_out_reached;
    logic                     r_out_held, n_out_held;

    // ------------------------------------------------------------------
    // Slot memory
    // ------------------------------------------------------------------
    logic                     w_wr_en;
    logic [ADDR_W-1:0]        w_wr_addr;
    sss_pkg::t_slot_entry     w_wr_entry;
    logic                     w_rd_en;
    logic [ADDR_W-1:0]        w_rd_addr;
    sss_pkg::t_slot_entry     w_rd_entry;

    sss_slot_ram #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_ram (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (w_wr_en),
        .i_wr_addr  (w_wr_addr),
        .i_wr_entry (w_wr_entry),
        .i_rd_en    (w_rd_en),
        .i_rd_addr  (w_rd_addr),
        .o_rd_entry (w_rd_entry)
    );

    // ------------------------------------------------------------------
    // Shared compare unit and helpers
    // ------------------------------------------------------------------
    logic [ADDR_W-1:0]        w_base;
    logic                     w_issue;
    logic signed [MW+1:0]     w_diff;
    logic                     w_used;
    logic                     w_take1;
    logic                     w_take2;
    logic [SLOT_W-1:0]        w_sel;
    logic signed [TW-1:0]     w_sel_temp;
    logic                     w_out_free;
    logic                     w_accept;
    logic                     w_scan_cmd;

    // The active table starts at entry 0 (heat) or entry NUM_SLOTS (cool).
    assign w_base  = r_cool_mode ? ADDR_W'(NUM_SLOTS) : '0;
    assign w_issue = (r_idx < IDX_W'(NUM_SLOTS));

    // Distance from the slot's start to the current minute. A slot wins the
    // first pass with the smallest non-negative distance under the limit,
    // and the second pass with the largest positive start. Strict compares
    // keep the lowest index on a tie, because slots are visited in order.
    assign w_diff  = $signed({2'b00, r_minute}) -
                     $signed({w_rd_entry.start[SW-1], w_rd_entry.start});
    assign w_used  = !w_rd_entry.start[SW-1];
    assign w_take1 = w_used && !w_diff[MW+1] && !w_diff[MW] && (w_diff[MW-1:0] < r_best1);
    assign w_take2 = w_used && (w_rd_entry.start[MW-1:0] > r_best2);

    // The first pass has priority; the second only serves when it found nothing.
    assign w_sel      = (r_sel1 != '0) ? r_sel1 : r_sel2;
    assign w_sel_temp = (r_sel1 != '0) ? r_t1 : r_t2;

    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_accept   = i_in_valid && (r_state == sss_pkg::S_IDLE);
    assign w_scan_cmd = (sss_pkg::t_cmd'(i_cmd) == sss_pkg::CMD_SET_OVERRIDE) ||
                        ((sss_pkg::t_cmd'(i_cmd) == sss_pkg::CMD_QUERY) && !r_vac_en);

    assign w_rd_en   = (r_state == sss_pkg::S_SCAN) && w_issue;
    assign w_rd_addr = w_base + ADDR_W'(r_idx[SLOT_W-1:0]);

    // ------------------------------------------------------------------
    // Sequencer: next state, state updates and result
    // ------------------------------------------------------------------
    always_comb begin
        n_state       = r_state;
        n_cool_mode   = r_cool_mode;
        n_vac_en      = r_vac_en;
        n_vac_sp      = r_vac_sp;
        n_ovr_active  = r_ovr_active;
        n_ovr_slot    = r_ovr_slot;
        n_ovr_temp    = r_ovr_temp;
        n_target      = r_target;
        n_cmd         = r_cmd;
        n_minute      = r_minute;
        n_tsel        = r_tsel;
        n_sidx        = r_sidx;
        n_sstart      = r_sstart;
        n_tval        = r_tval;
        n_idx         = r_idx;
        n_pend        = r_pend;
        n_pidx        = r_pidx;
        n_best1       = r_best1;
        n_sel1        = r_sel1;
        n_t1          = r_t1;
        n_best2       = r_best2;
        n_sel2        = r_sel2;
        n_t2          = r_t2;
        n_temp0       = r_temp0;
        n_out_valid   = r_out_valid && !i_out_ready;
        n_out_sp      = r_out_sp;
        n_out_reached = r_out_reached;
        n_out_held    = r_out_held;
        w_wr_en       = 1'b0;
        w_wr_addr     = w_base;
        w_wr_entry    = '{start: sss_pkg::UNUSED_START, temp: r_tval};

        // Configuration writes are to arrive only while the block is idle; the block itself does not enforce it.
        if (i_cfg_we) begin
            case (sss_pkg::t_reg_idx'(i_cfg_addr))
                sss_pkg::REG_COOL_MODE:         n_cool_mode = i_cfg_wdata[0];
                sss_pkg::REG_VACATION_ENABLE:   n_vac_en    = i_cfg_wdata[0];
                sss_pkg::REG_VACATION_SETPOINT: n_vac_sp    = $signed(i_cfg_wdata[TW-1:0]);
                default: ;
            endcase
        end

        case (r_state)
            sss_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_cmd    = sss_pkg::t_cmd'(i_cmd);
                    n_minute = i_minute_of_day;
                    n_tsel   = i_table_select;
                    n_sidx   = i_slot_index;
                    n_sstart = i_slot_start;
                    n_tval   = i_temp_value;
                    n_idx    = '0;
                    n_pend   = 1'b0;
                    n_best1  = MW'(sss_pkg::SEARCH_LIMIT);
                    n_sel1   = '0;
                    n_best2  = '0;
                    n_sel2   = '0;
                    n_state  = w_scan_cmd ? sss_pkg::S_SCAN : sss_pkg::S_FINISH;
                end
            end

            sss_pkg::S_SCAN: begin
                // Issue one read per cycle; the data of the previous read is
                // compared in the same cycle.
                n_pend = w_issue;
                n_pidx = r_idx[SLOT_W-1:0];
                n_idx  = r_idx + IDX_W'(1);
                if (r_pend) begin
                    if (r_pidx == '0) begin
                        n_temp0 = w_rd_entry.temp;
                    end else begin
                        if (w_take1) begin
                            n_best1 = w_diff[MW-1:0];
                            n_sel1  = r_pidx;
                            n_t1    = w_rd_entry.temp;
                        end
                        if (w_take2) begin
                            n_best2 = w_rd_entry.start[MW-1:0];
                            n_sel2  = r_pidx;
                            n_t2    = w_rd_entry.temp;
                        end
                    end
                end
                if (!w_issue) begin
                    n_state = sss_pkg::S_FINISH;
                end
            end

            sss_pkg::S_FINISH: begin
                // State is committed only in the cycle the result is loaded.
                if (w_out_free) begin
                    n_out_sp      = '0;
                    n_out_reached = 1'b0;
                    case (r_cmd)
                        sss_pkg::CMD_WRITE_SLOT: begin
                            if (int'(r_sidx) < NUM_SLOTS) begin
                                w_wr_en    = 1'b1;
                                w_wr_addr  = ADDR_W'(int'(r_tsel) * NUM_SLOTS + int'(r_sidx));
                                w_wr_entry = '{start: r_sstart, temp: r_tval};
                            end
                        end
                        sss_pkg::CMD_SET_OVERRIDE: begin
                            // Slot 0's start is never read, so it is written as unused.
                            w_wr_en      = 1'b1;
                            n_ovr_slot   = w_sel;
                            n_ovr_temp   = r_tval;
                            n_ovr_active = 1'b1;
                        end
                        sss_pkg::CMD_QUERY: begin
                            if (r_vac_en) begin
                                n_out_sp = r_vac_sp;
                            end else begin
                                n_out_sp = r_temp0;
                                if (w_sel != '0) begin
                                    n_target = w_sel_temp;
                                    if (!r_ovr_active || (r_ovr_slot != w_sel)) begin
                                        n_out_sp     = w_sel_temp;
                                        n_ovr_active = 1'b0;
                                    end
                                end
                            end
                        end
                        sss_pkg::CMD_CHECK: begin
                            n_out_reached = r_ovr_active &&
                                (((r_target > r_ovr_temp) && (r_tval <= r_ovr_temp)) ||
                                 ((r_target <= r_ovr_temp) && (r_tval >= r_ovr_temp)));
                        end
                        default: ;
                    endcase
                    n_out_held  = n_ovr_active;
                    n_out_valid = 1'b1;
                    n_state     = sss_pkg::S_IDLE;
                end
            end

            default: n_state = sss_pkg::S_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Control and architectural state
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= sss_pkg::S_IDLE;
            r_cool_mode  <= 1'b0;
            r_vac_en     <= 1'b0;
            r_vac_sp     <= '0;
            r_ovr_active <= 1'b0;
            r_ovr_slot   <= '0;
            r_ovr_temp   <= '0;
            r_target     <= '0;
            r_pend       <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_cool_mode  <= n_cool_mode;
            r_vac_en     <= n_vac_en;
            r_vac_sp     <= n_vac_sp;
            r_ovr_active <= n_ovr_active;
            r_ovr_slot   <= n_ovr_slot;
            r_ovr_temp   <= n_ovr_temp;
            r_target     <= n_target;
            r_pend       <= n_pend;
            r_out_valid  <= n_out_valid;
        end
    end

    // ------------------------------------------------------------------
    // Payload and scan registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        r_cmd         <= n_cmd;
        r_minute      <= n_minute;
        r_tsel        <= n_tsel;
        r_sidx        <= n_sidx;
        r_sstart      <= n_sstart;
        r_tval        <= n_tval;
        r_idx         <= n_idx;
        r_pidx        <= n_pidx;
        r_best1       <= n_best1;
        r_sel1        <= n_sel1;
        r_t1          <= n_t1;
        r_best2       <= n_best2;
        r_sel2        <= n_sel2;
        r_t2          <= n_t2;
        r_temp0       <= n_temp0;
        r_out_sp      <= n_out_sp;
        r_out_reached <= n_out_reached;
        r_out_held    <= n_out_held;
    end

    assign o_in_ready         = (r_state == sss_pkg::S_IDLE);
    assign o_out_valid        = r_out_valid;
    assign o_setpoint         = r_out_sp;
    assign o_override_reached = r_out_reached;
    assign o_override_held    = r_out_held;

endmodule

// ===== rtl/sss_checker.sv =====
// ============================================================================
// Setpoint selector port checker
// Watches the top level's ports and flags behavior that breaks its contract.
// ============================================================================
module sss_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_in_valid,
    input logic                              o_in_ready,
    input logic                              o_out_valid,
    input logic                              i_out_ready,
    input logic signed [sss_pkg::TEMP_W-1:0] o_setpoint,
    input logic                              o_override_reached,
    input logic                              o_override_held
);

    // A result word stays offered until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result word dropped before it was taken");

    // After reset the block is empty and ready for a word.
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && o_in_ready)
        else $error("block not idle after reset");

    // Only one word is worked on at a time.
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("second word accepted while one is in work");

    // A reached check can only pass while an override is held.
    a_reached_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_override_reached |-> o_override_held)
        else $error("override reached without an override held");

    // A reached check never carries a setpoint.
    a_reached_no_sp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_override_reached |-> (o_setpoint == '0))
        else $error("setpoint given with a reached check");

endmodule

bind schedule_setpoint_selector_unit sss_checker u_sss_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .i_in_valid         (i_in_valid),
    .o_in_ready         (o_in_ready),
    .o_out_valid        (o_out_valid),
    .i_out_ready        (i_out_ready),
    .o_setpoint         (o_setpoint),
    .o_override_reached (o_override_reached),
    .o_override_held    (o_override_held)
);
